// File: design/rsbd_pkg.sv
// Shared types and fixed field widths of the ring statistics descriptor.
package rsbd_pkg;

    localparam int PIX_W  = 16;
    localparam int POS_W  = 12;
    localparam int RC_W   = 5;
    localparam int RW_W   = 16;
    localparam int OUT_W  = 64;
    localparam int WIDX_W = 3;
    localparam int CNT_W  = 11;
    localparam int SUM_W  = 27;
    localparam int SQ_W   = 43;
    localparam int DVD_W  = CNT_W + SQ_W;
    localparam int DVS_W  = 2 * CNT_W;

    localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

    localparam logic REG_RING_COUNT = 1'b0;
    localparam logic REG_RING_WIDTH = 1'b1;

    typedef enum logic [1:0] {
        DIV_RING,
        DIV_MEAN,
        DIV_VAR
    } div_sel_t;

    typedef struct packed {
        logic     load_px;
        logic     sq;
        logic     chk;
        logic     start_div;
        div_sel_t div_sel;
        logic     upd_ring;
        logic     ld_stat;
        logic     wr_mean;
        logic     wr_var;
        logic     ld_row;
        logic     cmp;
        logic     emit;
        logic     emit_last;
        logic     clr;
    } rsbd_cmd_t;

    typedef struct packed {
        logic busy;
        logic in_range;
        logic last_px;
        logic cnt_zero;
        logic word_full;
        logic out_free;
    } rsbd_sts_t;

endpackage

// File: design/rsbd_ctrl.sv
// Sequencer for pixel binning, ring statistics and pair comparison.
module rsbd_ctrl
    import rsbd_pkg::*;
#(
    parameter int MAX_RINGS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [$clog2(MAX_RINGS+1)-1:0]     n_eff,
    input  rsbd_sts_t                          sts,
    output rsbd_cmd_t                          cmd,
    output logic [$clog2(MAX_RINGS)-1:0]       i_idx,
    output logic [$clog2(MAX_RINGS)-1:0]       j_idx
);

    localparam int RI_W = $clog2(MAX_RINGS);
    localparam int NW   = $clog2(MAX_RINGS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_CHK, ST_SQRT, ST_DIV, ST_END,
        ST_LD, ST_MUL, ST_DM, ST_DV, ST_ROW, ST_PAIR, ST_EMIT
    } state_t;

    state_t          state_reg;
    logic [RI_W-1:0] i_reg;
    logic [RI_W-1:0] j_reg;
    logic            fin_reg;
    logic [RI_W-1:0] nm1;
    logic            app;
    logic            fin;
    logic            flush;

    assign nm1   = RI_W'(n_eff - NW'(1));
    assign app   = (j_reg != i_reg);
    assign fin   = (i_reg == nm1) && (j_reg == nm1 - RI_W'(1));
    assign flush = fin || (app && sts.word_full);
    assign i_idx = i_reg;
    assign j_idx = j_reg;

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_px = s_valid;
            end
            ST_DIFF: cmd.sq  = 1'b1;
            ST_CHK:  cmd.chk = 1'b1;
            ST_SQRT: begin
                cmd.start_div = !sts.busy;
                cmd.div_sel   = DIV_RING;
            end
            ST_DIV:  cmd.upd_ring = !sts.busy;
            ST_END:  ;
            ST_LD:   cmd.ld_stat = 1'b1;
            ST_MUL: begin
                if (!sts.busy) begin
                    if (sts.cnt_zero) begin
                        cmd.wr_mean = 1'b1;
                        cmd.wr_var  = 1'b1;
                    end else begin
                        cmd.start_div = 1'b1;
                        cmd.div_sel   = DIV_MEAN;
                    end
                end
            end
            ST_DM: begin
                if (!sts.busy) begin
                    cmd.wr_mean   = 1'b1;
                    cmd.start_div = 1'b1;
                    cmd.div_sel   = DIV_VAR;
                end
            end
            ST_DV:   cmd.wr_var = !sts.busy;
            ST_ROW:  cmd.ld_row = 1'b1;
            ST_PAIR: cmd.cmp    = app;
            ST_EMIT: begin
                cmd.emit      = sts.out_free;
                cmd.emit_last = fin_reg;
                cmd.clr       = sts.out_free && fin_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            fin_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (s_valid) state_reg <= ST_DIFF;
                ST_DIFF: state_reg <= ST_CHK;
                ST_CHK:  state_reg <= sts.in_range ? ST_SQRT : ST_END;
                ST_SQRT: if (!sts.busy) state_reg <= ST_DIV;
                ST_DIV:  if (!sts.busy) state_reg <= ST_END;
                ST_END: begin
                    i_reg     <= '0;
                    state_reg <= sts.last_px ? ST_LD : ST_IDLE;
                end
                ST_LD:   state_reg <= ST_MUL;
                ST_MUL, ST_DV: begin
                    if (!sts.busy && (state_reg == ST_DV || sts.cnt_zero)) begin
                        // advance to the next ring, or start comparing
                        if (i_reg == nm1) begin
                            i_reg     <= '0;
                            state_reg <= ST_ROW;
                        end else begin
                            i_reg     <= i_reg + RI_W'(1);
                            state_reg <= ST_LD;
                        end
                    end else if (!sts.busy) begin
                        state_reg <= ST_DM;
                    end
                end
                ST_DM:   if (!sts.busy) state_reg <= ST_DV;
                ST_ROW: begin
                    j_reg     <= '0;
                    state_reg <= ST_PAIR;
                end
                ST_PAIR: begin
                    fin_reg <= fin;
                    if (j_reg == nm1) begin
                        j_reg <= '0;
                        i_reg <= i_reg + RI_W'(1);
                    end else begin
                        j_reg <= j_reg + RI_W'(1);
                    end
                    if (flush)
                        state_reg <= ST_EMIT;
                    else
                        state_reg <= (j_reg == nm1) ? ST_ROW : ST_PAIR;
                end
                ST_EMIT: begin
                    if (sts.out_free) begin
                        if (fin_reg) begin
                            i_reg     <= '0;
                            j_reg     <= '0;
                            fin_reg   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= (j_reg == '0) ? ST_ROW : ST_PAIR;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: design/rsbd_dp.sv
// Datapath: distance, shared iterative unit, ring store, comparison and output beat.
module rsbd_dp
    import rsbd_pkg::*;
#(
    parameter int MAX_RINGS = 16,
    parameter int WORD_BITS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [RW_W-1:0]                    cfg_data,
    input  logic [PIX_W-1:0]                   s_key_x,
    input  logic [PIX_W-1:0]                   s_key_y,
    input  logic [POS_W-1:0]                   s_pixel_row,
    input  logic [POS_W-1:0]                   s_pixel_col,
    input  logic [PIX_W-1:0]                   s_pixel_value,
    input  logic                               s_last_pixel,
    input  rsbd_cmd_t                          cmd,
    input  logic [$clog2(MAX_RINGS)-1:0]       i_idx,
    input  logic [$clog2(MAX_RINGS)-1:0]       j_idx,
    output rsbd_sts_t                          sts,
    output logic [$clog2(MAX_RINGS+1)-1:0]     n_eff,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [OUT_W-1:0]                   m_descriptor_word,
    output logic [WIDX_W-1:0]                  m_word_index,
    output logic                               m_last_word
);

    localparam int RI_W     = $clog2(MAX_RINGS);
    localparam int NW       = $clog2(MAX_RINGS + 1);
    localparam int LIM_W    = NW + 4;
    localparam int D2_W     = 2 * LIM_W;
    localparam int V_W      = D2_W + 8;
    localparam int RT_W     = LIM_W + 4;
    localparam int MEAN_W   = PIX_W + 8;
    localparam int VAR_W    = 2 * PIX_W;
    localparam int LEN_MEAN = SUM_W + 8;
    localparam int IT_W     = $clog2(DVD_W + 1);
    localparam int BP_W     = $clog2(WORD_BITS);

    typedef enum logic [1:0] {IT_SQRT, IT_DIV, IT_MUL} it_mode_t;

    // configuration
    logic [RC_W-1:0] rc_reg;
    logic [RW_W-1:0] rw_reg;
    logic [RW_W-1:0] rw_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg <= RC_W'(16);
            rw_reg <= RW_W'(256);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RING_COUNT: rc_reg <= cfg_data[RC_W-1:0];
                REG_RING_WIDTH: rw_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (rc_reg < RC_W'(2))
            n_eff = NW'(2);
        else if (32'(rc_reg) > MAX_RINGS)
            n_eff = NW'(MAX_RINGS);
        else
            n_eff = NW'(rc_reg);
    end
    assign rw_eff = (rw_reg == '0) ? RW_W'(1) : rw_reg;

    // pixel capture and squares
    logic signed [PIX_W+1:0] dx_s, dy_s;
    logic [PIX_W-1:0]        dxa_reg, dya_reg, val_reg;
    logic                    last_reg;
    logic [2*PIX_W-1:0]      dx2_reg, dy2_reg, vsq_reg;
    logic [2*PIX_W:0]        d2;
    logic [LIM_W-1:0]        lim;
    logic [D2_W-1:0]         lim2;
    logic                    in_range;

    assign dx_s = signed'({2'b00, s_pixel_col, 4'b0000}) - signed'({2'b00, s_key_x});
    assign dy_s = signed'({2'b00, s_pixel_row, 4'b0000}) - signed'({2'b00, s_key_y});

    always_ff @(posedge aclk) begin
        if (cmd.load_px) begin
            dxa_reg  <= dx_s[PIX_W+1] ? PIX_W'(-dx_s) : PIX_W'(dx_s);
            dya_reg  <= dy_s[PIX_W+1] ? PIX_W'(-dy_s) : PIX_W'(dy_s);
            val_reg  <= s_pixel_value;
            last_reg <= s_last_pixel;
        end
        if (cmd.sq) begin
            dx2_reg <= dxa_reg * dxa_reg;
            dy2_reg <= dya_reg * dya_reg;
            vsq_reg <= val_reg * val_reg;
        end
    end

    assign d2       = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign lim      = {n_eff, 4'b0000};
    assign lim2     = lim * lim;
    assign in_range = (d2 <= (2*PIX_W+1)'(lim2));

    // shared iterative unit: square root, restoring divide, shift-add multiply
    logic [IT_W-1:0]   it_cnt_reg;
    it_mode_t          mode_reg;
    logic              sq_start;
    logic              mul_start;
    logic              busy;

    logic [V_W-1:0]    sq_v_reg;
    logic [RT_W+1:0]   sq_rem_reg;
    logic [RT_W-1:0]   sq_root_reg;
    logic [RT_W+3:0]   sq_sh, sq_trial;

    logic [DVD_W-1:0]  dv_dvd_reg, dv_q_reg;
    logic [DVS_W-1:0]  dv_dvs_reg, dv_rem_reg;
    logic [DVS_W:0]    dv_sh;
    logic              dv_ge;
    logic [DVD_W-1:0]  dv_load;
    logic [DVS_W-1:0]  dvs_load;
    logic [IT_W-1:0]   dv_len;

    logic [DVD_W-1:0]  mul_mcand_reg, mul_acc_reg;
    logic [CNT_W-1:0]  mul_mplier_reg;

    logic [CNT_W-1:0]  st_c_reg;
    logic [SUM_W-1:0]  st_s_reg;
    logic [2*SUM_W-1:0] ss_reg;
    logic [DVS_W-1:0]  cc_reg;

    assign sq_start  = cmd.chk && in_range;
    assign mul_start = cmd.ld_stat;
    assign busy      = (it_cnt_reg != '0);

    always_comb begin
        unique case (cmd.div_sel)
            DIV_RING: begin
                dv_load  = {sq_root_reg, {(DVD_W-RT_W){1'b0}}};
                dvs_load = DVS_W'(rw_eff);
                dv_len   = IT_W'(RT_W);
            end
            DIV_MEAN: begin
                dv_load  = {st_s_reg, 8'h00, {(DVD_W-LEN_MEAN){1'b0}}};
                dvs_load = DVS_W'(st_c_reg);
                dv_len   = IT_W'(LEN_MEAN);
            end
            DIV_VAR: begin
                dv_load  = (mul_acc_reg > DVD_W'(ss_reg)) ?
                           mul_acc_reg - DVD_W'(ss_reg) : '0;
                dvs_load = cc_reg;
                dv_len   = IT_W'(DVD_W);
            end
            default: begin
                dv_load  = '0;
                dvs_load = DVS_W'(1);
                dv_len   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            it_cnt_reg <= '0;
            mode_reg   <= IT_SQRT;
        end else if (sq_start) begin
            it_cnt_reg <= IT_W'(RT_W);
            mode_reg   <= IT_SQRT;
        end else if (cmd.start_div) begin
            it_cnt_reg <= dv_len;
            mode_reg   <= IT_DIV;
        end else if (mul_start) begin
            it_cnt_reg <= IT_W'(CNT_W);
            mode_reg   <= IT_MUL;
        end else if (busy) begin
            it_cnt_reg <= it_cnt_reg - IT_W'(1);
        end
    end

    assign sq_sh    = {sq_rem_reg, sq_v_reg[V_W-1:V_W-2]};
    assign sq_trial = (RT_W+4)'({sq_root_reg, 2'b01});
    assign dv_sh    = {dv_rem_reg, dv_dvd_reg[DVD_W-1]};
    assign dv_ge    = (dv_sh >= {1'b0, dv_dvs_reg});

    always_ff @(posedge aclk) begin
        if (sq_start) begin
            sq_v_reg    <= {d2[D2_W-1:0], 8'h00};
            sq_rem_reg  <= '0;
            sq_root_reg <= '0;
        end else if (busy && mode_reg == IT_SQRT) begin
            sq_v_reg <= sq_v_reg << 2;
            if (sq_sh >= sq_trial) begin
                sq_rem_reg  <= (RT_W+2)'(sq_sh - sq_trial);
                sq_root_reg <= {sq_root_reg[RT_W-2:0], 1'b1};
            end else begin
                sq_rem_reg  <= (RT_W+2)'(sq_sh);
                sq_root_reg <= {sq_root_reg[RT_W-2:0], 1'b0};
            end
        end
        if (cmd.start_div) begin
            dv_dvd_reg <= dv_load;
            dv_dvs_reg <= dvs_load;
            dv_rem_reg <= '0;
            dv_q_reg   <= '0;
        end else if (busy && mode_reg == IT_DIV) begin
            dv_dvd_reg <= dv_dvd_reg << 1;
            dv_rem_reg <= dv_ge ? DVS_W'(dv_sh - {1'b0, dv_dvs_reg}) : DVS_W'(dv_sh);
            dv_q_reg   <= {dv_q_reg[DVD_W-2:0], dv_ge};
        end
    end

    // ring store
    logic [CNT_W-1:0]     cnt_mem [MAX_RINGS];
    logic [SUM_W-1:0]     sum_mem [MAX_RINGS];
    logic [SQ_W-1:0]      sq_mem  [MAX_RINGS];
    logic [MAX_RINGS-1:0] vld_reg;
    logic [RT_W-1:0]      q_ring, nm1_rt, b_rt;
    logic [RI_W-1:0]      ring_b, addr;
    logic [CNT_W-1:0]     rd_cnt;
    logic [SUM_W-1:0]     rd_sum;
    logic [SQ_W-1:0]      rd_sq;
    logic                 room;

    assign q_ring = dv_q_reg[RT_W-1:0];
    assign nm1_rt = RT_W'(n_eff) - RT_W'(1);
    assign b_rt   = (q_ring > nm1_rt) ? nm1_rt : q_ring;
    assign ring_b = RI_W'(b_rt);
    assign addr   = cmd.upd_ring ? ring_b : i_idx;
    assign rd_cnt = vld_reg[addr] ? cnt_mem[addr] : '0;
    assign rd_sum = vld_reg[addr] ? sum_mem[addr] : '0;
    assign rd_sq  = vld_reg[addr] ? sq_mem[addr]  : '0;
    assign room   = (rd_cnt < CNT_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (cmd.clr) begin
            vld_reg <= '0;
        end else if (cmd.upd_ring && room) begin
            vld_reg[ring_b] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.upd_ring && room) begin
            cnt_mem[ring_b] <= rd_cnt + CNT_W'(1);
            sum_mem[ring_b] <= rd_sum + SUM_W'(val_reg);
            sq_mem[ring_b]  <= rd_sq + SQ_W'(vsq_reg);
        end
    end

    // statistics of one ring
    always_ff @(posedge aclk) begin
        if (mul_start) begin
            st_c_reg       <= rd_cnt;
            st_s_reg       <= rd_sum;
            ss_reg         <= rd_sum * rd_sum;
            cc_reg         <= rd_cnt * rd_cnt;
            mul_mcand_reg  <= DVD_W'(rd_sq);
            mul_mplier_reg <= rd_cnt;
            mul_acc_reg    <= '0;
        end else if (busy && mode_reg == IT_MUL) begin
            if (mul_mplier_reg[0])
                mul_acc_reg <= mul_acc_reg + mul_mcand_reg;
            mul_mcand_reg  <= mul_mcand_reg << 1;
            mul_mplier_reg <= mul_mplier_reg >> 1;
        end
    end

    logic [MEAN_W-1:0] mean_mem [MAX_RINGS];
    logic [VAR_W-1:0]  var_mem  [MAX_RINGS];
    logic [MEAN_W-1:0] row_mean_reg;
    logic [VAR_W-1:0]  row_var_reg;
    logic              cnt_zero;

    assign cnt_zero = (st_c_reg == '0);

    always_ff @(posedge aclk) begin
        if (cmd.wr_mean)
            mean_mem[i_idx] <= cnt_zero ? '0 : dv_q_reg[MEAN_W-1:0];
        if (cmd.wr_var)
            var_mem[i_idx] <= cnt_zero ? '0 : dv_q_reg[VAR_W-1:0];
        if (cmd.ld_row) begin
            row_mean_reg <= mean_mem[i_idx];
            row_var_reg  <= var_mem[i_idx];
        end
    end

    // descriptor word assembly and output beat
    logic [WORD_BITS-1:0] word_reg, out_word_reg;
    logic [BP_W-1:0]      bp_reg;
    logic [WIDX_W-1:0]    word_cnt_reg, out_idx_reg;
    logic                 out_last_reg;
    logic                 m_valid_reg;
    logic                 word_full;

    assign word_full = (bp_reg == BP_W'(WORD_BITS - 2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg     <= '0;
            bp_reg       <= '0;
            word_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.cmp) begin
                word_reg[bp_reg +: 2] <= {row_var_reg > var_mem[j_idx],
                                          row_mean_reg > mean_mem[j_idx]};
                bp_reg <= word_full ? '0 : bp_reg + BP_W'(2);
            end else if (cmd.emit) begin
                word_reg     <= '0;
                bp_reg       <= '0;
                word_cnt_reg <= cmd.emit_last ? '0 : word_cnt_reg + WIDX_W'(1);
            end
            if (cmd.emit)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_word_reg <= word_reg;
            out_idx_reg  <= word_cnt_reg;
            out_last_reg <= cmd.emit_last;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_descriptor_word = OUT_W'(out_word_reg);
    assign m_word_index      = out_idx_reg;
    assign m_last_word       = out_last_reg;

    assign sts.busy      = busy;
    assign sts.in_range  = in_range;
    assign sts.last_px   = last_reg;
    assign sts.cnt_zero  = cnt_zero;
    assign sts.word_full = word_full;
    assign sts.out_free  = !m_valid_reg || m_ready;

endmodule

// File: design/ring_statistics_binary_descriptor.sv
// Ring statistics binary descriptor, top level.
//
// Pixels of one keypoint window enter on the s_ channel, one beat per pixel.
// Each beat inside the radius is binned by its distance from the keypoint into one of n rings
// (n = ring_count clamped to 2..MAX_RINGS), and the ring's count, sum and sum
// of squares are updated. The beat flagged s_last_pixel closes the window.
// A pixel outside the radius skips the shared unit; one inside runs its bit-serial
// square root and then its bit-serial ring divide. s_ready is low until a pixel is done.
// After the last pixel each ring with pixels runs an 11-step multiply, a 35-step
// mean divide and a 54-step variance divide; an empty ring runs the multiply only.
// Then each ring is compared with every other ring, and a word goes to the output
// register each time it fills and after the last pair.
// Results leave on the m_ channel as ceil(2*n*(n-1)/WORD_BITS) word beats;
// m_last_word marks the final one. A stalled receiver holds the output
// register and pauses the comparison; s_ready stays low until the last word
// has been handed to the output register.
// Reset loads ring_count 16 and ring_width 256 and empties the ring store;
// the store is emptied again after each descriptor. Write cfg_* only while
// the block is idle.
module ring_statistics_binary_descriptor
    import rsbd_pkg::*;
#(
    parameter int MAX_RINGS = 16,
    parameter int WORD_BITS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [RW_W-1:0]     cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [PIX_W-1:0]    s_key_x,
    input  logic [PIX_W-1:0]    s_key_y,
    input  logic [POS_W-1:0]    s_pixel_row,
    input  logic [POS_W-1:0]    s_pixel_col,
    input  logic [PIX_W-1:0]    s_pixel_value,
    input  logic                s_last_pixel,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [OUT_W-1:0]    m_descriptor_word,
    output logic [WIDX_W-1:0]   m_word_index,
    output logic                m_last_word
);

    localparam int RI_W = $clog2(MAX_RINGS);
    localparam int NW   = $clog2(MAX_RINGS + 1);

    rsbd_cmd_t       cmd;
    rsbd_sts_t       sts;
    logic [RI_W-1:0] i_idx, j_idx;
    logic [NW-1:0]   n_eff;

    rsbd_ctrl #(
        .MAX_RINGS(MAX_RINGS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .n_eff   (n_eff),
        .sts     (sts),
        .cmd     (cmd),
        .i_idx   (i_idx),
        .j_idx   (j_idx)
    );

    rsbd_dp #(
        .MAX_RINGS(MAX_RINGS),
        .WORD_BITS(WORD_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_key_x           (s_key_x),
        .s_key_y           (s_key_y),
        .s_pixel_row       (s_pixel_row),
        .s_pixel_col       (s_pixel_col),
        .s_pixel_value     (s_pixel_value),
        .s_last_pixel      (s_last_pixel),
        .cmd               (cmd),
        .i_idx             (i_idx),
        .j_idx             (j_idx),
        .sts               (sts),
        .n_eff             (n_eff),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_descriptor_word (m_descriptor_word),
        .m_word_index      (m_word_index),
        .m_last_word       (m_last_word)
    );

endmodule

// File: design/rsbd_chk.sv
// Port-level checker for the ring statistics descriptor, bound to the top level.
module rsbd_chk
    import rsbd_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [OUT_W-1:0]  m_descriptor_word,
    input logic [WIDX_W-1:0] m_word_index,
    input logic              m_last_word
);

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_descriptor_word)
                                && $stable(m_word_index) && $stable(m_last_word))
        else $error("stalled output beat changed");

    a_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    a_mid_desc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_word |-> !s_ready)
        else $error("input opened before descriptor finished");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output beat valid after reset");

endmodule

bind ring_statistics_binary_descriptor rsbd_chk u_rsbd_chk (.*);
